[hdl/hfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types and constants of the heightfield height sampler.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int MAX_CELLS   = 128;
  localparam int STORE_DEPTH = (MAX_CELLS + 1) * (MAX_CELLS + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int VADDR_W     = 18;
  localparam logic [VADDR_W-1:0] DEPTH_V = VADDR_W'(STORE_DEPTH);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

  // Restoring divider step counts: cell divide and final rounding divide.
  localparam logic [5:0] CELL_DIV_STEPS  = 6'd33;
  localparam logic [5:0] ROUND_DIV_STEPS = 6'd36;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] REG_CELLS_X   = 2'd0;
  localparam logic [1:0] REG_CELLS_Z   = 2'd1;
  localparam logic [1:0] REG_CELL_SIZE = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [31:0] x_pos;
    logic signed [31:0] z_pos;
    logic               adjust_height;
    logic [14:0]        vertex_index;
    logic signed [31:0] vertex_height;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] x_clamped;
    logic signed [31:0] z_clamped;
    logic signed [31:0] height_out;
  } out_word_t;

  typedef struct packed {
    logic               is_write;
    logic               adjust;
    logic signed [31:0] x_c;
    logic signed [31:0] z_c;
    logic [14:0]        vaddr;
    logic signed [31:0] vheight;
  } q_entry_t;

  typedef struct packed {
    logic [7:0]  cells_x;
    logic [7:0]  cells_z;
    logic [24:0] cell_size;
    logic [31:0] hx;
    logic [31:0] hz;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_CHECK, ST_ADDR,
    ST_RD0, ST_RD1, ST_RD2, ST_RD3,
    ST_MUL1, ST_MUL2, ST_MUL3, ST_NUM, ST_NUM2, ST_QDIV,
    ST_FIX1, ST_FIX2, ST_OUT
  } back_state_t;

endpackage

[hdl/hfs_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module hfs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  hfs_pkg::q_entry_t wr_data,
  output logic             fifo_full,
  input  logic             rd_en,
  output hfs_pkg::q_entry_t rd_data,
  output logic             fifo_nempty
);

  hfs_pkg::q_entry_t mem_r [hfs_pkg::FIFO_DEPTH];
  logic [hfs_pkg::FIFO_PW-1:0] wp_r, rp_r;
  logic [hfs_pkg::FIFO_PW:0]   cnt_r;

  assign fifo_full   = (cnt_r == (hfs_pkg::FIFO_PW+1)'(hfs_pkg::FIFO_DEPTH));
  assign fifo_nempty = (cnt_r != '0);
  assign rd_data     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

[hdl/hfs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hfs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,   // left aligned, MSB first
  input  logic [25:0] rem_init,
  input  logic [5:0]  steps,
  input  logic [25:0] divisor,
  output logic        done,
  output logic [39:0] quo,
  output logic [25:0] rem
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [63:0] dvd_r;
  logic [25:0] rem_r, div_r;
  logic [39:0] quo_r;
  logic [26:0] trial;
  logic        fits;

  assign trial = {rem_r, dvd_r[63]};
  assign fits  = (trial >= {1'b0, div_r});
  assign done  = done_r;
  assign quo   = quo_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= rem_init;
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[62:0], 1'b0};
      rem_r <= fits ? 26'(trial - {1'b0, div_r}) : trial[25:0];
      quo_r <= {quo_r[38:0], fits};
    end
  end

endmodule

[hdl/hfs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_front
// Accept words, clamp query positions and hand them to the queue.
// ----------------------------------------------------------------------------
module hfs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hfs_pkg::in_word_t    in_word,
  output logic                 full,
  input  hfs_pkg::cfg_t        cfg,
  input  hfs_pkg::back_status_t status,
  input  logic                 fifo_full,
  output logic                 fifo_push,
  output hfs_pkg::q_entry_t    fifo_entry
);

  logic              slot_valid_r, slot_valid_nxt;
  hfs_pkg::in_word_t slot_r;
  logic              accept;
  logic signed [32:0] hxw, hzw, xw, zw, xc, zc;

  assign full      = status.clearing | (slot_valid_r & fifo_full);
  assign accept    = push & ~full;
  assign fifo_push = slot_valid_r & ~fifo_full;
  assign slot_valid_nxt = accept | (slot_valid_r & ~fifo_push);

  always_comb begin
    hxw = $signed({1'b0, cfg.hx});
    hzw = $signed({1'b0, cfg.hz});
    xw  = $signed({slot_r.x_pos[31], slot_r.x_pos});
    zw  = $signed({slot_r.z_pos[31], slot_r.z_pos});
    if (xw < -hxw)     xc = -hxw;
    else if (xw > hxw) xc = hxw;
    else               xc = xw;
    if (zw < -hzw)     zc = -hzw;
    else if (zw > hzw) zc = hzw;
    else               zc = zw;
    fifo_entry.is_write = (slot_r.command == hfs_pkg::CMD_WRITE);
    fifo_entry.adjust   = slot_r.adjust_height;
    fifo_entry.x_c      = xc[31:0];
    fifo_entry.z_c      = zc[31:0];
    fifo_entry.vaddr    = slot_r.vertex_index;
    fifo_entry.vheight  = slot_r.vertex_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) slot_valid_r <= 1'b0;
    else        slot_valid_r <= slot_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) slot_r <= in_word;
  end

endmodule

[hdl/hfs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_back
// Height store, cell search, triangle interpolation and result register.
// ----------------------------------------------------------------------------
module hfs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hfs_pkg::cfg_t         cfg,
  input  logic                  fifo_nempty,
  input  hfs_pkg::q_entry_t     head,
  output logic                  fifo_pop,
  output hfs_pkg::back_status_t status,
  output logic                  empty,
  input  logic                  pop,
  output hfs_pkg::out_word_t    out_word
);

  hfs_pkg::back_state_t state_r, state_nxt;

  logic signed [31:0] mem [hfs_pkg::STORE_DEPTH];
  logic [hfs_pkg::ADDR_W-1:0] clr_cnt_r;
  logic                        mem_we;
  logic [hfs_pkg::ADDR_W-1:0]  mem_waddr;
  logic signed [31:0]          mem_wdata;
  logic [hfs_pkg::VADDR_W-1:0] rd_addr;
  logic signed [31:0]          rd_data_r, rd_val;
  logic                        oob_r;

  logic        dx_start, dz_start, dx_done, dz_done;
  logic [63:0] dx_dvd;
  logic [25:0] dx_rem0, dx_divisor;
  logic [5:0]  dx_steps;
  logic [39:0] dx_quo, dz_quo;
  logic [25:0] dx_rem, dz_rem;
  logic [32:0] ux, uz;

  logic signed [31:0] xc_r, zc_r, h_r;
  logic [7:0]  ix_r;
  logic [24:0] tx_r, tz_r;
  logic [16:0] izs_r;
  logic [8:0]  stride;
  logic [hfs_pkg::VADDR_W-1:0] base_r;
  logic        ge_r, neg_r, outside, load_out;
  logic signed [31:0] h00_r, ha_r;
  logic signed [32:0] d1_r, d2_r;
  logic signed [58:0] prod_r;
  logic signed [59:0] acc_r;
  logic signed [61:0] nval_r;
  logic [61:0]        mag;
  logic signed [37:0] q_r, hsum;
  logic [24:0]        c1, c2;
  logic               out_valid_r;
  hfs_pkg::out_word_t out_r;

  assign status.clearing = (state_r == hfs_pkg::ST_CLEAR);
  assign empty    = ~out_valid_r;
  assign out_word = out_r;
  assign stride   = {1'b0, cfg.cells_x} + 9'd1;
  assign ux = {head.x_c[31], head.x_c} + {1'b0, cfg.hx};
  assign uz = {1'b0, cfg.hz} - {head.z_c[31], head.z_c};
  assign outside = (dx_quo[39:8] != '0) || (dx_quo[7:0] >= cfg.cells_x) ||
                   (dz_quo[39:8] != '0) || (dz_quo[7:0] >= cfg.cells_z);
  assign rd_val = oob_r ? 32'sd0 : rd_data_r;
  assign mag    = nval_r[61] ? 62'(-nval_r) : 62'(nval_r);
  assign c1     = ge_r ? tx_r : tz_r;
  assign c2     = ge_r ? tz_r : tx_r;
  assign hsum   = 38'(h00_r) + q_r;

  // Divider operands: cell search in IDLE, rounding divide in NUM2.
  always_comb begin
    if (state_r == hfs_pkg::ST_NUM2) begin
      dx_dvd     = {mag[35:0], 28'd0};
      dx_rem0    = {1'b0, mag[60:36]};
      dx_steps   = hfs_pkg::ROUND_DIV_STEPS;
      dx_divisor = {cfg.cell_size, 1'b0};
    end else begin
      dx_dvd     = {ux, 31'd0};
      dx_rem0    = '0;
      dx_steps   = hfs_pkg::CELL_DIV_STEPS;
      dx_divisor = {1'b0, cfg.cell_size};
    end
  end

  hfs_div u_divx (
    .clk, .rst_n, .start(dx_start), .dividend(dx_dvd), .rem_init(dx_rem0),
    .steps(dx_steps), .divisor(dx_divisor), .done(dx_done), .quo(dx_quo), .rem(dx_rem)
  );

  hfs_div u_divz (
    .clk, .rst_n, .start(dz_start), .dividend({uz, 31'd0}), .rem_init(26'd0),
    .steps(hfs_pkg::CELL_DIV_STEPS), .divisor({1'b0, cfg.cell_size}),
    .done(dz_done), .quo(dz_quo), .rem(dz_rem)
  );

  always_comb begin
    state_nxt = state_r;
    fifo_pop  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = head.vaddr;
    mem_wdata = head.vheight;
    dx_start  = 1'b0;
    dz_start  = 1'b0;
    load_out  = 1'b0;
    rd_addr   = base_r;
    unique case (state_r)
      hfs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == hfs_pkg::LAST_ADDR) state_nxt = hfs_pkg::ST_IDLE;
      end
      hfs_pkg::ST_IDLE: begin
        if (fifo_nempty) begin
          fifo_pop = 1'b1;
          if (head.is_write) begin
            mem_we = ({3'd0, head.vaddr} < hfs_pkg::DEPTH_V);
          end else if (head.adjust && cfg.cell_size != '0) begin
            dx_start  = 1'b1;
            dz_start  = 1'b1;
            state_nxt = hfs_pkg::ST_DIV;
          end else begin
            state_nxt = hfs_pkg::ST_OUT;
          end
        end
      end
      hfs_pkg::ST_DIV:   if (dx_done && dz_done) state_nxt = hfs_pkg::ST_CHECK;
      hfs_pkg::ST_CHECK: state_nxt = outside ? hfs_pkg::ST_OUT : hfs_pkg::ST_ADDR;
      hfs_pkg::ST_ADDR:  state_nxt = hfs_pkg::ST_RD0;
      hfs_pkg::ST_RD0: begin
        rd_addr   = base_r;
        state_nxt = hfs_pkg::ST_RD1;
      end
      hfs_pkg::ST_RD1: begin
        rd_addr   = ge_r ? base_r + 18'd1 : base_r + 18'(stride);
        state_nxt = hfs_pkg::ST_RD2;
      end
      hfs_pkg::ST_RD2: begin
        rd_addr   = base_r + 18'(stride) + 18'd1;
        state_nxt = hfs_pkg::ST_RD3;
      end
      hfs_pkg::ST_RD3:  state_nxt = hfs_pkg::ST_MUL1;
      hfs_pkg::ST_MUL1: state_nxt = hfs_pkg::ST_MUL2;
      hfs_pkg::ST_MUL2: state_nxt = hfs_pkg::ST_MUL3;
      hfs_pkg::ST_MUL3: state_nxt = hfs_pkg::ST_NUM;
      hfs_pkg::ST_NUM:  state_nxt = hfs_pkg::ST_NUM2;
      hfs_pkg::ST_NUM2: begin
        dx_start  = 1'b1;
        state_nxt = hfs_pkg::ST_QDIV;
      end
      hfs_pkg::ST_QDIV: if (dx_done) state_nxt = hfs_pkg::ST_FIX1;
      hfs_pkg::ST_FIX1: state_nxt = hfs_pkg::ST_FIX2;
      hfs_pkg::ST_FIX2: state_nxt = hfs_pkg::ST_OUT;
      hfs_pkg::ST_OUT: begin
        if (!out_valid_r || pop) begin
          load_out  = 1'b1;
          state_nxt = hfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hfs_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hfs_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (load_out)  out_valid_r <= 1'b1;
      else if (pop)  out_valid_r <= 1'b0;
    end
  end

  // Height store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr[hfs_pkg::ADDR_W-1:0]];
    oob_r     <= (rd_addr >= hfs_pkg::DEPTH_V);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      hfs_pkg::ST_IDLE: begin
        xc_r <= head.x_c;
        zc_r <= head.z_c;
        h_r  <= '0;
      end
      hfs_pkg::ST_CHECK: begin
        ix_r  <= dx_quo[7:0];
        tx_r  <= dx_rem[24:0];
        tz_r  <= dz_rem[24:0];
        ge_r  <= (dx_rem >= dz_rem);
        izs_r <= dz_quo[7:0] * stride;
      end
      hfs_pkg::ST_ADDR: base_r <= 18'(izs_r) + 18'(ix_r);
      hfs_pkg::ST_RD1:  h00_r <= rd_val;
      hfs_pkg::ST_RD2:  ha_r  <= rd_val;
      hfs_pkg::ST_RD3: begin
        d1_r <= 33'(ha_r) - 33'(h00_r);
        d2_r <= 33'(rd_val) - 33'(ha_r);
      end
      hfs_pkg::ST_MUL1: prod_r <= $signed({1'b0, c1}) * d1_r;
      hfs_pkg::ST_MUL2: begin
        acc_r  <= 60'(prod_r);
        prod_r <= $signed({1'b0, c2}) * d2_r;
      end
      hfs_pkg::ST_MUL3: acc_r  <= acc_r + 60'(prod_r);
      hfs_pkg::ST_NUM:  nval_r <= (62'(acc_r) <<< 1) + $signed({37'd0, cfg.cell_size});
      hfs_pkg::ST_NUM2: neg_r  <= nval_r[61];
      hfs_pkg::ST_FIX1: begin
        if (neg_r) q_r <= -($signed({2'b00, dx_quo[35:0]}) + 38'(dx_rem != '0));
        else       q_r <= $signed({2'b00, dx_quo[35:0]});
      end
      hfs_pkg::ST_FIX2: begin
        if (hsum > 38'sh0_7FFF_FFFF)       h_r <= 32'sh7FFF_FFFF;
        else if (hsum < -38'sh0_8000_0000) h_r <= 32'sh8000_0000;
        else                               h_r <= hsum[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.x_clamped  <= xc_r;
      out_r.z_clamped  <= zc_r;
      out_r.height_out <= h_r;
    end
  end

endmodule

[hdl/heightfield_height_sampler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_height_sampler_unit
// Vertex height store with clamped position queries and triangle sampling.
// ----------------------------------------------------------------------------
//  channel | ports                          | accepted when
//  --------+--------------------------------+--------------------------------
//  input   | push, full, in_word            | push & !full
//  result  | pop, empty, out_word           | pop & !empty
//  config  | psel penable pwrite paddr ...  | psel & penable & pwrite
//
//  A vertex write passes the front slot and the queue and reaches the store
//  in the back's IDLE state; a query without height goes from IDLE straight
//  to OUT. Each word holds the back until it is done.
//  A query with height runs a cell search (x and z restoring dividers in
//  parallel, one quotient bit per cycle), then, for a cell inside the grid,
//  three reads over the single read port of the height store, the multiply
//  and accumulate steps MUL1 to MUL3 and a rounding divide on the x
//  divider.
//  After reset the store is zeroed one entry per cycle: full stays high until
//  all 16641 entries are cleared; configuration writes are taken throughout.
//  The front holds one word and the queue four, so input and result stall
//  apart from each other; a result not yet popped holds the back.
// ----------------------------------------------------------------------------
module heightfield_height_sampler_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  hfs_pkg::in_word_t  in_word,
  output logic               empty,
  input  logic               pop,
  output hfs_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]  cells_x_r, cells_z_r;
  logic [24:0] cell_size_r;
  logic [31:0] hx_r, hz_r;
  logic [32:0] hx_prod, hz_prod;
  logic        cfg_we;

  hfs_pkg::cfg_t         cfg;
  hfs_pkg::back_status_t status;
  hfs_pkg::q_entry_t     f_entry, f_head;
  logic                  f_push, f_full, f_pop, f_nempty;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  // Register file; half extents are registered from it in the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r   <= 8'd100;
      cells_z_r   <= 8'd100;
      cell_size_r <= 25'd196608;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        hfs_pkg::REG_CELLS_X:   cells_x_r   <= pwdata[7:0];
        hfs_pkg::REG_CELLS_Z:   cells_z_r   <= pwdata[7:0];
        hfs_pkg::REG_CELL_SIZE: cell_size_r <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  assign hx_prod = cells_x_r * cell_size_r;
  assign hz_prod = cells_z_r * cell_size_r;

  always_ff @(posedge clk) begin
    hx_r <= hx_prod[32:1];
    hz_r <= hz_prod[32:1];
  end

  always_comb begin
    unique case (paddr[3:2])
      hfs_pkg::REG_CELLS_X:   prdata = {24'd0, cells_x_r};
      hfs_pkg::REG_CELLS_Z:   prdata = {24'd0, cells_z_r};
      hfs_pkg::REG_CELL_SIZE: prdata = {7'd0, cell_size_r};
      default:                prdata = '0;
    endcase
  end

  assign cfg.cells_x   = cells_x_r;
  assign cfg.cells_z   = cells_z_r;
  assign cfg.cell_size = cell_size_r;
  assign cfg.hx        = hx_r;
  assign cfg.hz        = hz_r;

  hfs_front u_front (
    .clk, .rst_n, .push, .in_word, .full, .cfg, .status,
    .fifo_full(f_full), .fifo_push(f_push), .fifo_entry(f_entry)
  );

  hfs_fifo u_fifo (
    .clk, .rst_n, .wr_en(f_push), .wr_data(f_entry), .fifo_full(f_full),
    .rd_en(f_pop), .rd_data(f_head), .fifo_nempty(f_nempty)
  );

  hfs_back u_back (
    .clk, .rst_n, .cfg, .fifo_nempty(f_nempty), .head(f_head), .fifo_pop(f_pop),
    .status, .empty, .pop, .out_word
  );

endmodule

[hdl/hfs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_checker
// Port-level checks of the height sampler, bound to the top level.
// ----------------------------------------------------------------------------
module hfs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               pready,
  input hfs_pkg::out_word_t out_word
);

  // The store clear blocks input right after reset.
  a_rst_full: assert property (@(posedge clk) !rst_n |=> full)
    else $error("full low after reset");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting result changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind heightfield_height_sampler_unit hfs_checker u_hfs_checker (.*);
